### rtl/core/mcl_pkg.sv
// ----------------------------------------------------------------------------
// mcl_pkg
// Shared types, field layout and format tables of the mip chain layout unit.
// ----------------------------------------------------------------------------
package mcl_pkg;

    // Input field widths
    localparam int FMT_W  = 5;
    localparam int TYPE_W = 2;
    localparam int SIZE_W = 13;
    localparam int REQ_W  = 4;

    // Output field widths
    localparam int LVL_W    = 4;
    localparam int BYTES_W  = 41;
    localparam int OFFS_W   = 41;
    localparam int TTEX_W   = 40;
    localparam int TBYTES_W = 44;

    // Internal arithmetic widths
    localparam int WH_W     = 2 * SIZE_W;
    localparam int VOX_W    = 3 * SIZE_W;
    localparam int ACC_W    = 44;
    localparam int TEXEL_W  = 5;

    // Stream payload widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 216;
    localparam int M_TUSER_W = 1;

    localparam logic [LVL_W-1:0] RESULT_CAP = 4'd13;
    localparam int               FMT_COUNT  = 23;

    localparam logic [TYPE_W-1:0] TYPE_1D   = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_2D   = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_3D   = 2'd2;
    localparam logic [TYPE_W-1:0] TYPE_CUBE = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic resolve;
        logic mul_wh;
        logic mul_vox;
        logic mul_bytes;
        logic acc;
        logic emit;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic err;   // request beyond the chain, valid during resolve
        logic done;  // current emit is the final result
    } sts_t;

    function automatic logic [TEXEL_W-1:0] texel_bytes(input logic [FMT_W-1:0] fmt);
        logic [TEXEL_W-1:0] b;
        unique case (fmt)
            5'd1, 5'd2, 5'd3, 5'd6, 5'd10, 5'd13: b = 5'd2;
            5'd4, 5'd5:                           b = 5'd1;
            5'd7:                                 b = 5'd3;
            5'd8, 5'd9, 5'd11, 5'd14, 5'd16, 5'd22: b = 5'd4;
            5'd12, 5'd15, 5'd17:                  b = 5'd8;
            5'd18:                                b = 5'd16;
            default:                              b = 5'd0;
        endcase
        return b;
    endfunction

    function automatic logic can_mip(input logic [FMT_W-1:0] fmt);
        logic m;
        if (fmt == 5'd0 || fmt == 5'd16 || fmt == 5'd17 || fmt == 5'd18 ||
            fmt >= 5'd22)
        begin
            m = 1'b0;
        end
        else
        begin
            m = 1'b1;
        end
        return m;
    endfunction

    // Position of the highest set bit, 0 for a value of 0 or 1
    function automatic logic [LVL_W-1:0] floor_log2(input logic [SIZE_W-1:0] v);
        logic [LVL_W-1:0] n;
        n = '0;
        for (int i = 1; i < SIZE_W; i++)
        begin
            if (v[i])
            begin
                n = LVL_W'(i);
            end
        end
        return n;
    endfunction

endpackage

### rtl/core/mcl_ctrl.sv
// ----------------------------------------------------------------------------
// mcl_ctrl
// Sequencer: accepts a description, steps each level through the datapath
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module mcl_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output mcl_pkg::cmd_t cmd,
    input  mcl_pkg::sts_t sts
);
    import mcl_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_RESOLVE   = 7'b0000010,
        S_MUL_WH    = 7'b0000100,
        S_MUL_VOX   = 7'b0001000,
        S_MUL_BYTES = 7'b0010000,
        S_ACC       = 7'b0100000,
        S_EMIT      = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RESOLVE;
                end
            end
            S_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = sts.err ? S_EMIT : S_MUL_WH;
            end
            S_MUL_WH:
            begin
                cmd.mul_wh = 1'b1;
                state_next = S_MUL_VOX;
            end
            S_MUL_VOX:
            begin
                cmd.mul_vox = 1'b1;
                state_next  = S_MUL_BYTES;
            end
            S_MUL_BYTES:
            begin
                cmd.mul_bytes = 1'b1;
                state_next    = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.done ? S_IDLE : S_MUL_WH;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_tready))
        else $error("result written over an untaken result");

    a_accept_resolve: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_RESOLVE))
        else $error("accepted description not resolved");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.emit))
        else $error("result valid raised without an emit");

endmodule

### rtl/core/mcl_datapath.sv
// ----------------------------------------------------------------------------
// mcl_datapath
// Description registers, level count resolve, size/byte product chain,
// running sums and the result register.
// ----------------------------------------------------------------------------
module mcl_datapath
#(
    parameter int MAX_SIZE_LOG2 = 12
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mcl_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [mcl_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic [mcl_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [mcl_pkg::M_TUSER_W-1:0]    m_tuser,
    output logic                             m_tlast,
    input  mcl_pkg::cmd_t                    cmd,
    output mcl_pkg::sts_t                    sts
);
    import mcl_pkg::*;

    localparam logic [31:0] TOP = 32'd1 << MAX_SIZE_LOG2;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        if (s == '0)
        begin
            r = SIZE_W'(1);
        end
        else if ({{(32-SIZE_W){1'b0}}, s} > TOP)
        begin
            r = TOP[SIZE_W-1:0];
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    // Description fields
    logic [FMT_W-1:0]   in_fmt;
    logic [TYPE_W-1:0]  in_type;
    logic [SIZE_W-1:0]  sx, sy, sz;
    logic [REQ_W-1:0]   in_req;

    assign in_fmt  = s_tdata[4:0];
    assign in_type = s_tuser[1:0];
    assign sx      = clamp_size(s_tdata[17:5]);
    assign sy      = clamp_size(s_tdata[30:18]);
    assign sz      = clamp_size(s_tdata[43:31]);
    assign in_req  = s_tdata[47:44];

    logic [SIZE_W-1:0]  w_reg, h_reg, d_reg;
    logic [TEXEL_W-1:0] pix_reg;
    logic               mip_reg, cube_reg, err_reg;
    logic [REQ_W-1:0]   req_reg;
    logic [LVL_W-1:0]   count_reg, lvl_reg;
    logic [WH_W-1:0]    wh_reg;
    logic [VOX_W-1:0]   vox_reg;
    logic [ACC_W-1:0]   bytes_reg, offset_reg, off_end_reg;
    logic [TTEX_W-1:0]  texels_reg;

    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_err_reg, out_last_reg;

    // Level count resolve
    logic [LVL_W-1:0] lw, lh, ld, lmax, maxl, count_c;
    logic             err_c, last_c;

    always_comb
    begin
        lw   = floor_log2(w_reg);
        lh   = floor_log2(h_reg);
        ld   = floor_log2(d_reg);
        lmax = lw;
        if (lh > lmax)
        begin
            lmax = lh;
        end
        if (ld > lmax)
        begin
            lmax = ld;
        end
        maxl  = lmax + LVL_W'(1);
        err_c = mip_reg && (req_reg > maxl);
        priority if (!mip_reg)
        begin
            count_c = LVL_W'(1);
        end
        else if (req_reg == '0)
        begin
            count_c = maxl;
        end
        else
        begin
            count_c = req_reg;
        end
        if (count_c > RESULT_CAP)
        begin
            count_c = RESULT_CAP;
        end
    end

    assign last_c   = err_reg || (lvl_reg == count_reg - LVL_W'(1));
    assign sts.err  = err_c;
    assign sts.done = last_c;

    // Totals for the final result, times six for cube maps
    logic [TTEX_W-1:0]   tot_tex;
    logic [TBYTES_W-1:0] tot_bytes;

    always_comb
    begin
        if (cube_reg)
        begin
            tot_tex   = (texels_reg << 2) + (texels_reg << 1);
            tot_bytes = (off_end_reg << 2) + (off_end_reg << 1);
        end
        else
        begin
            tot_tex   = texels_reg;
            tot_bytes = off_end_reg;
        end
    end

    // Result word, lowest field first
    logic [M_TDATA_W-1:0] level_word;

    always_comb
    begin
        level_word = '0;
        if (!err_reg)
        begin
            level_word[3:0]     = lvl_reg;
            level_word[16:4]    = w_reg;
            level_word[29:17]   = h_reg;
            level_word[42:30]   = d_reg;
            level_word[83:43]   = bytes_reg[BYTES_W-1:0];
            level_word[124:84]  = offset_reg[OFFS_W-1:0];
            level_word[128:125] = count_reg;
            if (last_c)
            begin
                level_word[168:129] = tot_tex;
                level_word[212:169] = tot_bytes;
            end
        end
    end

    // Control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg   <= 1'b0;
            count_reg <= '0;
            lvl_reg   <= '0;
        end
        else
        begin
            if (cmd.resolve)
            begin
                err_reg   <= err_c;
                count_reg <= count_c;
                lvl_reg   <= '0;
            end
            else if (cmd.emit)
            begin
                lvl_reg <= lvl_reg + LVL_W'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg    <= sx;
            h_reg    <= (in_type == TYPE_1D) ? SIZE_W'(1) :
                        ((in_type == TYPE_CUBE) ? sx : sy);
            d_reg    <= (in_type == TYPE_3D) ? sz : SIZE_W'(1);
            pix_reg  <= texel_bytes(in_fmt);
            mip_reg  <= can_mip(in_fmt);
            cube_reg <= (in_type == TYPE_CUBE);
            req_reg  <= in_req;
        end
        if (cmd.resolve)
        begin
            offset_reg <= '0;
            texels_reg <= '0;
        end
        if (cmd.mul_wh)
        begin
            wh_reg <= WH_W'(w_reg) * WH_W'(h_reg);
        end
        if (cmd.mul_vox)
        begin
            vox_reg <= VOX_W'(wh_reg) * VOX_W'(d_reg);
        end
        if (cmd.mul_bytes)
        begin
            bytes_reg  <= ACC_W'(vox_reg) * ACC_W'(pix_reg);
            texels_reg <= texels_reg + TTEX_W'(vox_reg);
        end
        if (cmd.acc)
        begin
            off_end_reg <= offset_reg + bytes_reg;
        end
        if (cmd.emit)
        begin
            out_data_reg <= level_word;
            out_err_reg  <= err_reg;
            out_last_reg <= last_c;
            offset_reg   <= off_end_reg;
            if (w_reg > SIZE_W'(1))
            begin
                w_reg <= w_reg >> 1;
            end
            if (h_reg > SIZE_W'(1))
            begin
                h_reg <= h_reg >> 1;
            end
            if (d_reg > SIZE_W'(1))
            begin
                d_reg <= d_reg >> 1;
            end
        end
    end

    assign m_tdata = out_data_reg;
    assign m_tuser = out_err_reg;
    assign m_tlast = out_last_reg;

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && err_reg) |=> (out_last_reg && out_err_reg))
        else $error("error result not marked final");

    a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !err_reg) |-> (lvl_reg < count_reg))
        else $error("level index beyond resolved count");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.resolve |=> (err_reg || (count_reg != '0 && count_reg <= RESULT_CAP)))
        else $error("resolved level count out of range");

endmodule

### rtl/core/mipmap_chain_layout_unit.sv
// ----------------------------------------------------------------------------
// mipmap_chain_layout_unit
// Resolves the mip chain of one texture description and streams one result
// per level: dimensions, byte size, byte offset and, on the last, totals.
// ----------------------------------------------------------------------------
//
//   channel | dir | carries                         | transfer when
//   --------+-----+---------------------------------+------------------------
//   s_*     | in  | one texture description         | s_tvalid && s_tready
//   m_*     | out | one result per mip level        | m_tvalid && m_tready
//
// Sequence: a description is taken and its level count resolved; an error
// result then goes straight to emit, else each level runs the five-step
// level sequence through the shared multiply chain (w*h, *d, *texel bytes,
// offset add, emit). A new description is taken only once the previous
// one has written its final result into the output register.
// Reset: rst_n clears the sequencer and the result valid flag; no sweep.
// Stalls: a low m_tready with a result pending freezes the sequencer at the emit step;
// the output register holds the pending result meanwhile.
// ----------------------------------------------------------------------------
module mipmap_chain_layout_unit
#(
    parameter int MAX_SIZE_LOG2 = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // description
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [4:0] format, [17:5] size_x, [30:18] size_y, [43:31] size_z,
    // [47:44] requested_levels
    input  logic [mcl_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] tex_type
    input  logic [mcl_pkg::S_TUSER_W-1:0] s_tuser,
    // level results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [3:0] level_index, [16:4] width, [29:17] height, [42:30] depth,
    // [83:43] level_bytes, [124:84] level_offset, [128:125] level_count,
    // [168:129] total_texels, [212:169] total_bytes, [215:213] zero
    output logic [mcl_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] error
    output logic [mcl_pkg::M_TUSER_W-1:0] m_tuser,
    // final result of the description
    output logic                          m_tlast
);
    import mcl_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer: one step of the level chain per cycle, except while the emit step waits for the output
    mcl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // Datapath: clamps, products, running sums, result register
    mcl_datapath
    #(
        .MAX_SIZE_LOG2 (MAX_SIZE_LOG2)
    )
    u_datapath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
